### hw/rtl/positional_list_insert_delete_defines.svh
// ----------------------------------------------------------------------------
// Positional list assertion macros
// Shorthand for the concurrent checks used inside the positional list RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define PLID_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("positional list check failed");

// Next-cycle implication, disabled while in reset
`define PLID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("positional list check failed");

`endif

### hw/rtl/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg
// Operation codes, status codes and sequencer states of the positional list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plid_pkg;

  // Request operations
  typedef enum logic [2:0] {
    FN_READ     = 3'd0,
    FN_INS_HEAD = 3'd1,
    FN_INS_TAIL = 3'd2,
    FN_INS_POS  = 3'd3,
    FN_DELETE   = 3'd4
  } plid_func_e;

  // Result status
  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2
  } plid_status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUT,
    S_READ_WAIT,
    S_FINISH
  } plid_state_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

endpackage

`default_nettype wire

### hw/rtl/plid_ram.sv
// ----------------------------------------------------------------------------
// plid_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plid_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/positional_list_insert_delete.sv
// Sequencing: a read passes S_DECODE, S_READ_WAIT and S_FINISH; a rejected or unused
// request passes S_DECODE and S_FINISH; each moved entry adds S_MOVE_RD and S_MOVE_WR.
// Throughput: one request at a time; an insert ends in S_PUT, and every entry
// moved goes through the single RAM read port and write port in turn.
// Reset: asynchronous, clears entry count, sequencer and output valid;
// list storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of signed 32-bit values in a RAM, with read, insert and delete
// by position; inserts and deletes shift entries one at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_insert_delete_defines.svh"

module positional_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    func_i,
  input  logic signed [plid_pkg::DataW-1:0] position_i,
  input  logic signed [plid_pkg::DataW-1:0] item_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [plid_pkg::DataW-1:0] read_value_o,
  output logic [1:0]                    status_o,
  output logic [plid_pkg::CountW-1:0]   entry_count_o
);

  import plid_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  plid_state_e state_q, state_d;

  logic [2:0]       func_q, func_d;
  logic [DataW-1:0] pos_q, pos_d;
  logic [DataW-1:0] val_q, val_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    tgt_q, tgt_d;
  logic             ins_q, ins_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DataW-1:0] rv_q, rv_d;
  logic [1:0]       st_q, st_d;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_rv_q, out_rv_d;
  logic [1:0]       out_st_q, out_st_d;
  logic [CountW-1:0] out_cnt_q, out_cnt_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [DataW-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [DataW-1:0] ram_rdata;

  logic             in_beat;
  logic             pos_neg;
  logic [DataW-2:0] pos_low;
  logic [DataW-2:0] cnt_wide;
  logic             pos_valid;
  logic             pos_le_cnt;
  logic             pos_head;
  logic             list_full;
  logic [CW-1:0]    last_idx;
  logic [CW-1:0]    idx_ext;
  logic [AW-1:0]    ins_tgt;
  logic             ins_bad;
  logic [CW+CountW-1:0] cnt_pad;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;

  // Position checks against the current count
  assign pos_neg    = pos_q[DataW-1];
  assign pos_low    = pos_q[DataW-2:0];
  assign cnt_wide   = (DataW-1)'(cnt_q);
  assign pos_valid  = !pos_neg && (pos_low < cnt_wide);
  assign pos_le_cnt = !pos_neg && (pos_low <= cnt_wide);
  assign pos_head   = pos_neg || (pos_low == '0);
  assign list_full  = (cnt_q == CW'(CAPACITY));
  assign last_idx   = cnt_q - CW'(1);
  assign idx_ext    = CW'(idx_q);

  // Insert target and range rejection
  always_comb begin
    ins_tgt = '0;
    ins_bad = 1'b0;
    case (func_q)
      FN_INS_TAIL: ins_tgt = cnt_q[AW-1:0];
      FN_INS_POS: begin
        ins_tgt = pos_head ? '0 : pos_q[AW-1:0];
        ins_bad = !pos_head && !pos_le_cnt;
      end
      default: ins_tgt = '0;
    endcase
  end

  // Sequencer: next state, datapath controls, RAM access
  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    pos_d     = pos_q;
    val_d     = val_q;
    idx_d     = idx_q;
    tgt_d     = tgt_q;
    ins_d     = ins_q;
    cnt_d     = cnt_q;
    rv_d      = rv_q;
    st_d      = st_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ram_rdata;
    ram_raddr = ins_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          func_d  = func_i;
          pos_d   = position_i;
          val_d   = item_value_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        rv_d = '0;
        st_d = STAT_DONE;
        case (func_q)
          FN_READ: begin
            ram_raddr = pos_q[AW-1:0];
            if (pos_valid) begin
              state_d = S_READ_WAIT;
            end else begin
              rv_d    = '1;
              st_d    = STAT_BADPOS;
              state_d = S_FINISH;
            end
          end
          FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
            if (ins_bad) begin
              st_d    = STAT_BADPOS;
              state_d = S_FINISH;
            end else if (list_full) begin
              st_d    = STAT_FULL;
              state_d = S_FINISH;
            end else begin
              idx_d   = cnt_q[AW-1:0];
              tgt_d   = ins_tgt;
              ins_d   = 1'b1;
              state_d = (cnt_q[AW-1:0] == ins_tgt) ? S_PUT : S_MOVE_RD;
            end
          end
          FN_DELETE: begin
            if (!pos_valid) begin
              st_d    = STAT_BADPOS;
              state_d = S_FINISH;
            end else begin
              idx_d = pos_q[AW-1:0];
              ins_d = 1'b0;
              if (CW'(pos_q[AW-1:0]) == last_idx) begin
                cnt_d   = last_idx;
                state_d = S_FINISH;
              end else begin
                state_d = S_MOVE_RD;
              end
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_MOVE_RD: begin
        // Read the neighbor that moves into the current slot
        state_d = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        ram_we = 1'b1;
        if (ins_q) begin
          idx_d   = idx_q - AW'(1);
          state_d = ((idx_q - AW'(1)) == tgt_q) ? S_PUT : S_MOVE_RD;
        end else begin
          idx_d = idx_q + AW'(1);
          if ((idx_ext + CW'(1)) == last_idx) begin
            cnt_d   = last_idx;
            state_d = S_FINISH;
          end else begin
            state_d = S_MOVE_RD;
          end
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = val_q;
        cnt_d     = cnt_q + CW'(1);
        state_d   = S_FINISH;
      end
      S_READ_WAIT: begin
        rv_d    = ram_rdata;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register: load on finish when the slot is free, drop on beat
  assign cnt_pad = {{CountW{1'b0}}, cnt_q};

  always_comb begin
    out_valid_d = out_valid_q;
    out_rv_d    = out_rv_q;
    out_st_d    = out_st_q;
    out_cnt_d   = out_cnt_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_FINISH) && (!out_valid_q || out_ready_i)) begin
      out_valid_d = 1'b1;
      out_rv_d    = rv_q;
      out_st_d    = st_q;
      out_cnt_d   = cnt_pad[CountW-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    tgt_q     <= tgt_d;
    ins_q     <= ins_d;
    rv_q      <= rv_d;
    st_q      <= st_d;
    out_rv_q  <= out_rv_d;
    out_st_q  <= out_st_d;
    out_cnt_q <= out_cnt_d;
  end

  // List storage
  plid_ram #(
    .Width (DataW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_rv_q;
  assign status_o      = out_st_q;
  assign entry_count_o = out_cnt_q;

  // Checks
  `PLID_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CW'(CAPACITY))
  `PLID_ASSERT_IMPL(a_full_status, (state_q == S_FINISH) && (st_q == STAT_FULL),
                    list_full)
  `PLID_ASSERT_IMPL(a_move_in_range, (state_q == S_MOVE_RD) || (state_q == S_MOVE_WR),
                    idx_ext < cnt_q || (ins_q && idx_ext == cnt_q))
  `PLID_ASSERT_NEXT(a_beat_decodes, in_beat, state_q == S_DECODE)

endmodule

`default_nettype wire
